>>> rtl/core/pmsu_pkg.sv
// ----------------------------------------------------------------------------
// pmsu_pkg
// Shared constants, types and tables of the Potts lattice site update core:
// lattice geometry, field widths, neighbor offsets, the Q0.64 decay step and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pmsu_pkg;

   // Lattice geometry
   localparam int LAT_W  = 256;
   localparam int LAT_H  = 256;
   localparam int ADDR_W = $clog2(LAT_W * LAT_H);
   // Coordinate width for neighbor math: holds any column or row plus one
   localparam int CRD_W  = 11;

   // Field widths
   localparam int SITE_W = 8;
   localparam int SPIN_W = 4;
   localparam int RND_W  = 16;
   localparam int DE_W   = 7;
   localparam int ETOT_W = 32;
   localparam int MAG_W  = 20;
   localparam int TEMP_W = 8;
   localparam int FSTR_W = 2;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_INV_TEMP  = 2'd0,
      CSR_FIELD_STR = 2'd1,
      CSR_FIELD_DIR = 2'd2,
      CSR_DIAGONAL  = 2'd3
   } csr_idx_type;

   localparam logic [TEMP_W-1:0] INV_TEMP_RESET = 8'd5;

   // Neighbor walk: center first, then four orthogonal, then four diagonal
   localparam int NB_COUNT = 9;
   localparam int NB_W     = $clog2(NB_COUNT);
   localparam logic [NB_W-1:0] NB_CENTER     = 4'd0;
   localparam logic [NB_W-1:0] NB_LAST_ORTHO = 4'd4;
   localparam logic [NB_W-1:0] NB_LAST_DIAG  = 4'd8;

   localparam logic signed [1:0] NB_DX [NB_COUNT] =
      '{2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1};
   localparam logic signed [1:0] NB_DY [NB_COUNT] =
      '{2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd1};

   // Acceptance threshold: exp(-p/32) in Q0.64, zero from this product on
   localparam int CUTOFF   = 355;
   localparam int P_W      = 14;
   localparam int POW_BITS = $clog2(CUTOFF);
   localparam int K_W      = $clog2(POW_BITS + 1);
   localparam int Q_W      = 64;
   localparam int HALF_W   = 32;

   // Series terms for exp(-1/32), each truncated as it is formed
   localparam logic [Q_W-1:0] EXP_T1  = 64'h0800_0000_0000_0000;
   localparam logic [Q_W-1:0] EXP_T2  = EXP_T1 / 64'd64;
   localparam logic [Q_W-1:0] EXP_T3  = EXP_T2 / 64'd96;
   localparam logic [Q_W-1:0] EXP_T4  = EXP_T3 / 64'd128;
   localparam logic [Q_W-1:0] EXP_T5  = EXP_T4 / 64'd160;
   localparam logic [Q_W-1:0] EXP_T6  = EXP_T5 / 64'd192;
   localparam logic [Q_W-1:0] EXP_T7  = EXP_T6 / 64'd224;
   localparam logic [Q_W-1:0] EXP_T8  = EXP_T7 / 64'd256;
   localparam logic [Q_W-1:0] EXP_T9  = EXP_T8 / 64'd288;
   localparam logic [Q_W-1:0] EXP_T10 = EXP_T9 / 64'd320;
   localparam logic [Q_W-1:0] EXP_T11 = EXP_T10 / 64'd352;
   localparam logic [Q_W-1:0] EXP_T12 = EXP_T11 / 64'd384;
   localparam logic [Q_W-1:0] EXP_STEP_Q64 = 64'd0 - EXP_T1 + EXP_T2 - EXP_T3
      + EXP_T4 - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9 + EXP_T10
      - EXP_T11 + EXP_T12;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_POW_START,
      ST_POW_WAIT,
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DECIDE,
      ST_THR_BIT,
      ST_THR_WAIT,
      ST_COMMIT
   } pmsu_state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;   // write zero at sweep address, advance
      logic req_load;     // capture request
      logic read_issue;   // read current neighbor, advance
      logic p_load;       // capture threshold exponent, restart bit walk
      logic mul_start;    // launch multiplier
      logic mul_pow;      // operand select: square the current power
      logic pow_store;    // store next power, advance bit index
      logic res_take;     // first factor of the result, advance
      logic res_store;    // product into result, advance
      logic k_skip;       // advance bit index
      logic commit;       // write site, update totals, load result
   } pmsu_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic pow_last;
      logic mul_done;
      logic in_range;
      logic read_last;
      logic need_thr;
      logic bit_set;
      logic have;
      logic bit_end;
      logic out_free;
   } pmsu_status_type;

endpackage

>>> rtl/core/pmsu_qmul.sv
// ----------------------------------------------------------------------------
// pmsu_qmul
// Q0.64 by Q0.64 multiplier keeping the upper 64 bits of the product. One
// 32x32 multiplier works through the four partial products in turn; the
// result is ready when done rises and holds until the next start.
// ----------------------------------------------------------------------------
module pmsu_qmul (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [pmsu_pkg::Q_W-1:0] a,
   input  logic [pmsu_pkg::Q_W-1:0] b,
   output logic                    done,
   output logic [pmsu_pkg::Q_W-1:0] product
);
   import pmsu_pkg::*;

   logic                busy_ff, busy_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [Q_W-1:0]      a_ff, b_ff;
   logic [Q_W-1:0]      prod_ff, prod_in;
   logic [HALF_W+1:0]   mid_ff, mid_in;
   logic [Q_W-1:0]      hi_ff, hi_in;
   logic [HALF_W-1:0]   op_a, op_b;

   // Pick halves: step 0 low*low, 1 low*high, 2 high*low, 3 high*high
   always_comb begin
      op_a    = cnt_ff[1] ? a_ff[Q_W-1:HALF_W] : a_ff[HALF_W-1:0];
      op_b    = cnt_ff[0] ? b_ff[Q_W-1:HALF_W] : b_ff[HALF_W-1:0];
      prod_in = Q_W'(op_a) * Q_W'(op_b);
   end

   // Accumulate the partial product of the previous step
   always_comb begin
      mid_in = mid_ff;
      hi_in  = hi_ff;
      case (cnt_ff)
         3'd1: begin
            mid_in = mid_ff + (HALF_W+2)'(prod_ff[Q_W-1:HALF_W]);
         end
         3'd2, 3'd3: begin
            mid_in = mid_ff + (HALF_W+2)'(prod_ff[HALF_W-1:0]);
            hi_in  = hi_ff + Q_W'(prod_ff[Q_W-1:HALF_W]);
         end
         3'd4: begin
            hi_in = hi_ff + prod_ff;
         end
         default: begin
            mid_in = mid_ff;
         end
      endcase
      if (start) begin
         mid_in = '0;
         hi_in  = '0;
      end
   end

   // Sequence control
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   assign done    = busy_ff && (cnt_ff == 3'd5);
   assign product = hi_ff + Q_W'(mid_ff[HALF_W+1:HALF_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      prod_ff <= prod_in;
      mid_ff  <= mid_in;
      hi_ff   <= hi_in;
   end

endmodule

>>> rtl/core/pmsu_ctrl.sv
// ----------------------------------------------------------------------------
// pmsu_ctrl
// Sequencer of the site update: clearing sweep and power table setup after
// reset, then per request the lattice reads, threshold evaluation and commit.
// ----------------------------------------------------------------------------
module pmsu_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pmsu_pkg::pmsu_status_type    status,
   output pmsu_pkg::pmsu_cmd_type       cmd
);
   import pmsu_pkg::*;

   pmsu_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_POW_START;
            end
         end
         ST_POW_START: begin
            cmd.mul_start = 1'b1;
            cmd.mul_pow   = 1'b1;
            state_in      = ST_POW_WAIT;
         end
         ST_POW_WAIT: begin
            cmd.mul_pow = 1'b1;
            if (status.mul_done) begin
               cmd.pow_store = 1'b1;
               state_in      = status.pow_last ? ST_IDLE : ST_POW_START;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            if (!status.in_range) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.read_issue = 1'b1;
               if (status.read_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.p_load = 1'b1;
            state_in   = ST_THR_BIT;
         end
         ST_THR_BIT: begin
            if (!status.need_thr || status.bit_end) begin
               state_in = ST_COMMIT;
            end else if (status.bit_set) begin
               if (status.have) begin
                  cmd.mul_start = 1'b1;
                  state_in      = ST_THR_WAIT;
               end else begin
                  cmd.res_take = 1'b1;
               end
            end else begin
               cmd.k_skip = 1'b1;
            end
         end
         ST_THR_WAIT: begin
            if (status.mul_done) begin
               cmd.res_store = 1'b1;
               state_in      = ST_THR_BIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/pmsu_dpath.sv
// ----------------------------------------------------------------------------
// pmsu_dpath
// Datapath of the site update: lattice memory, neighbor walk and energy
// accumulation, exp(-p/32) threshold by square-and-multiply over a stored
// table of base powers, running totals and the result register.
// ----------------------------------------------------------------------------
module pmsu_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  pmsu_pkg::pmsu_cmd_type              cmd,
   output pmsu_pkg::pmsu_status_type           status,
   input  logic                                req_mode,
   input  logic [pmsu_pkg::SITE_W-1:0]         req_site_x,
   input  logic [pmsu_pkg::SITE_W-1:0]         req_site_y,
   input  logic [pmsu_pkg::SPIN_W-1:0]         req_proposed_spin,
   input  logic [pmsu_pkg::RND_W-1:0]          req_random_value,
   input  logic [pmsu_pkg::TEMP_W-1:0]         inv_temperature,
   input  logic [pmsu_pkg::FSTR_W-1:0]         field_weight,
   input  logic [pmsu_pkg::SPIN_W-1:0]         field_direction,
   input  logic                                include_diagonal,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pmsu_pkg::DE_W-1:0]    rsp_energy_change,
   output logic                                rsp_accepted,
   output logic [pmsu_pkg::SPIN_W-1:0]         rsp_old_spin,
   output logic signed [pmsu_pkg::ETOT_W-1:0]  rsp_energy_total,
   output logic [pmsu_pkg::MAG_W-1:0]          rsp_magnetization_total
);
   import pmsu_pkg::*;

   // Lattice memory
   logic [SPIN_W-1:0] lat_mem [LAT_W*LAT_H];
   logic [SPIN_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [SPIN_W-1:0] mem_wdata;

   // Request
   logic              mode_ff;
   logic [SITE_W-1:0] x_ff, y_ff;
   logic [SPIN_W-1:0] sf_ff;
   logic [RND_W-1:0]  rnd_ff;
   logic              in_range_ff;
   logic [ADDR_W-1:0] ctr_addr_ff;

   // Walk and sweep
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [NB_W-1:0]   nb_ff, nb_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rd_use_ff;
   logic [NB_W-1:0]   rd_tag_ff;
   logic signed [1:0] dx, dy;
   logic [CRD_W-1:0]  nx, ny;
   logic              nb_ok;
   logic [ADDR_W-1:0] nb_addr;
   logic [NB_W-1:0]   nb_last;

   // Energy
   logic [SPIN_W-1:0] si_ff, si_in;
   logic [DE_W-1:0]   de_ff, de_in;
   logic              de_le0;

   // Threshold
   logic [P_W-1:0]    p_ff;
   logic [K_W-1:0]    k_ff, k_in;
   logic              have_ff, have_in;
   logic [Q_W-1:0]    pw_ff [POW_BITS];
   logic [Q_W-1:0]    pw_k;
   logic [Q_W-1:0]    res_ff;
   logic [Q_W-1:0]    mul_a;
   logic              mul_done;
   logic [Q_W-1:0]    mul_res;
   logic              trial_ok;
   logic              acc;

   // Totals and result
   logic [ETOT_W-1:0] etot_ff, etot_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DE_W-1:0]   rsp_de_ff;
   logic              rsp_acc_ff;
   logic [SPIN_W-1:0] rsp_old_ff;
   logic [ETOT_W-1:0] rsp_etot_ff;
   logic [MAG_W-1:0]  rsp_mag_ff;

   function automatic logic [DE_W-1:0] bonus(input logic [SPIN_W-1:0] spin,
                                             input logic [SPIN_W-1:0] dir,
                                             input logic [FSTR_W-1:0] strength);
      bonus = (spin == dir) ? DE_W'(strength) : '0;
   endfunction

   // Neighbor address and bounds
   always_comb begin
      dx      = NB_DX[nb_ff];
      dy      = NB_DY[nb_ff];
      nx      = CRD_W'(x_ff) + {{(CRD_W-2){dx[1]}}, dx};
      ny      = CRD_W'(y_ff) + {{(CRD_W-2){dy[1]}}, dy};
      nb_ok   = (nx < CRD_W'(LAT_W)) && (ny < CRD_W'(LAT_H));
      nb_addr = ADDR_W'(32'(ny) * 32'(LAT_W) + 32'(nx));
      if (!mode_ff) begin
         nb_last = NB_CENTER;
      end else if (include_diagonal) begin
         nb_last = NB_LAST_DIAG;
      end else begin
         nb_last = NB_LAST_ORTHO;
      end
   end

   // Acceptance decision
   always_comb begin
      pw_k     = pw_ff[k_ff];
      mul_a    = cmd.mul_pow ? pw_k : res_ff;
      de_le0   = de_ff[DE_W-1] || (de_ff == '0);
      if (de_le0) begin
         trial_ok = 1'b1;
      end else if (p_ff == '0) begin
         trial_ok = (rnd_ff != {RND_W{1'b1}});
      end else begin
         trial_ok = (p_ff < P_W'(CUTOFF)) && (rnd_ff < res_ff[Q_W-1:Q_W-RND_W]);
      end
      acc = in_range_ff && (!mode_ff || trial_ok);
   end

   // Memory port select
   always_comb begin
      if (cmd.clear_step) begin
         mem_addr = clr_addr_ff;
      end else if (cmd.commit) begin
         mem_addr = ctr_addr_ff;
      end else begin
         mem_addr = nb_addr;
      end
      mem_we    = cmd.clear_step || (cmd.commit && acc);
      mem_wdata = cmd.clear_step ? '0 : sf_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lat_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= lat_mem[mem_addr];
   end

   // Control next state: sweep, walk, bit index, totals, result valid
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      nb_in        = nb_ff;
      rd_vld_in    = cmd.read_issue;
      k_in         = k_ff;
      have_in      = have_ff;
      etot_in      = etot_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         k_in        = '0;
      end
      if (cmd.req_load) begin
         nb_in = '0;
      end else if (cmd.read_issue) begin
         nb_in = nb_ff + NB_W'(1);
      end
      if (cmd.p_load) begin
         k_in    = '0;
         have_in = 1'b0;
      end
      if (cmd.pow_store || cmd.res_take || cmd.res_store || cmd.k_skip) begin
         k_in = k_ff + K_W'(1);
      end
      if (cmd.res_take) begin
         have_in = 1'b1;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (acc) begin
            mag_in = mag_ff - MAG_W'(si_ff) + MAG_W'(sf_ff);
            if (mode_ff) begin
               etot_in = etot_ff + {{(ETOT_W-DE_W){de_ff[DE_W-1]}}, de_ff};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         nb_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         k_ff         <= '0;
         have_ff      <= 1'b0;
         etot_ff      <= '0;
         mag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         nb_ff        <= nb_in;
         rd_vld_ff    <= rd_vld_in;
         k_ff         <= k_in;
         have_ff      <= have_in;
         etot_ff      <= etot_in;
         mag_ff       <= mag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Own spin from the center read, energy from each in-lattice neighbor read
   always_comb begin
      si_in = si_ff;
      de_in = de_ff;
      if (cmd.req_load) begin
         si_in = '0;
         de_in = '0;
      end else if (rd_vld_ff) begin
         if (rd_tag_ff == NB_CENTER) begin
            si_in = rd_data_ff;
         end else if (rd_use_ff) begin
            de_in = de_ff
                  + ((rd_data_ff == si_ff) ? DE_W'(2) : '0)
                  - ((rd_data_ff == sf_ff) ? DE_W'(2) : '0)
                  + bonus(si_ff, field_direction, field_weight)
                  - bonus(sf_ff, field_direction, field_weight);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      si_ff <= si_in;
      de_ff <= de_in;
      if (cmd.req_load) begin
         mode_ff     <= req_mode;
         x_ff        <= req_site_x;
         y_ff        <= req_site_y;
         sf_ff       <= req_proposed_spin;
         rnd_ff      <= req_random_value;
         in_range_ff <= (CRD_W'(req_site_x) < CRD_W'(LAT_W))
                     && (CRD_W'(req_site_y) < CRD_W'(LAT_H));
         ctr_addr_ff <= ADDR_W'(32'(req_site_y) * 32'(LAT_W) + 32'(req_site_x));
      end
      if (cmd.read_issue) begin
         rd_tag_ff <= nb_ff;
         rd_use_ff <= nb_ok;
      end
      if (cmd.p_load) begin
         p_ff <= de_le0 ? '0 : P_W'(de_ff[DE_W-2:0]) * P_W'(inv_temperature);
      end
      if (cmd.clear_step) begin
         pw_ff[0] <= EXP_STEP_Q64;
      end
      if (cmd.pow_store) begin
         pw_ff[K_W'(k_ff + K_W'(1))] <= mul_res;
      end
      if (cmd.res_take) begin
         res_ff <= pw_k;
      end else if (cmd.res_store) begin
         res_ff <= mul_res;
      end
      if (cmd.commit) begin
         rsp_de_ff   <= de_ff;
         rsp_acc_ff  <= acc;
         rsp_old_ff  <= si_ff;
         rsp_etot_ff <= etot_in;
         rsp_mag_ff  <= mag_in;
      end
   end

   pmsu_qmul u_qmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (pw_k),
      .done    (mul_done),
      .product (mul_res)
   );

   // Status to the controller
   always_comb begin
      status.clear_last = (clr_addr_ff == ADDR_W'(LAT_W * LAT_H - 1));
      status.pow_last   = (k_ff == K_W'(POW_BITS - 2));
      status.mul_done   = mul_done;
      status.in_range   = in_range_ff;
      status.read_last  = (nb_ff == nb_last);
      status.need_thr   = mode_ff && !de_le0 && (p_ff != '0) && (p_ff < P_W'(CUTOFF));
      status.bit_set    = p_ff[k_ff];
      status.have       = have_ff;
      status.bit_end    = (k_ff == K_W'(POW_BITS));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_energy_change       = $signed(rsp_de_ff);
   assign rsp_accepted            = rsp_acc_ff;
   assign rsp_old_spin            = rsp_old_ff;
   assign rsp_energy_total        = $signed(rsp_etot_ff);
   assign rsp_magnetization_total = rsp_mag_ff;

endmodule

>>> rtl/core/potts_metropolis_site_update_core.sv
// ----------------------------------------------------------------------------
// potts_metropolis_site_update_core
// Holds a q-state Potts lattice with open edges and runs single-site
// Metropolis trials against it. Load requests write a site; trial requests
// report dE, the acceptance and the running energy and spin totals.
// ----------------------------------------------------------------------------
// After reset the core sweeps the lattice memory to spin zero, one site per
// cycle, then forms the nine powers exp(-2^k/32) by repeated squaring;
// req_ready stays low until both are done, while register writes are taken
// throughout. One request is worked at a time, and the single-port lattice
// memory sets the pace: the center site and the neighbors are read one per
// cycle, and an accepted update takes a write. A load reads only its own
// site; a trial reads the center and four neighbors, or eight with the
// diagonals on. When dE <= 0 or the threshold is saturated or zero, the
// threshold walk is skipped. Otherwise the walk steps through the bits of
// dE*inv_temperature and does one 64-bit multiply per set bit but the first,
// at most 7. A site outside the lattice skips the reads and goes straight to
// commit. A new request is taken while the previous result still waits on
// rsp_ready.
module potts_metropolis_site_update_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_mode,
   input  logic [pmsu_pkg::SITE_W-1:0]            req_site_x,
   input  logic [pmsu_pkg::SITE_W-1:0]            req_site_y,
   input  logic [pmsu_pkg::SPIN_W-1:0]            req_proposed_spin,
   input  logic [pmsu_pkg::RND_W-1:0]             req_random_value,
   // Result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pmsu_pkg::DE_W-1:0]       rsp_energy_change,
   output logic                                   rsp_accepted,
   output logic [pmsu_pkg::SPIN_W-1:0]            rsp_old_spin,
   output logic signed [pmsu_pkg::ETOT_W-1:0]     rsp_energy_total,
   output logic [pmsu_pkg::MAG_W-1:0]             rsp_magnetization_total,
   // Register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [pmsu_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [pmsu_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [pmsu_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import pmsu_pkg::*;

   logic [TEMP_W-1:0] inv_temp_ff, inv_temp_in;
   logic [FSTR_W-1:0] field_str_ff, field_str_in;
   logic [SPIN_W-1:0] field_dir_ff, field_dir_in;
   logic              diag_ff, diag_in;
   logic              csr_wr;
   pmsu_cmd_type      cmd;
   pmsu_status_type   status;

   // Register writes
   always_comb begin
      csr_wr       = psel && penable && pwrite && pready;
      inv_temp_in  = inv_temp_ff;
      field_str_in = field_str_ff;
      field_dir_in = field_dir_ff;
      diag_in      = diag_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            CSR_INV_TEMP:  inv_temp_in  = pwdata[TEMP_W-1:0];
            CSR_FIELD_STR: field_str_in = pwdata[FSTR_W-1:0];
            CSR_FIELD_DIR: field_dir_in = pwdata[SPIN_W-1:0];
            CSR_DIAGONAL:  diag_in      = pwdata[0];
            default:       diag_in      = diag_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_temp_ff  <= INV_TEMP_RESET;
         field_str_ff <= '0;
         field_dir_ff <= '0;
         diag_ff      <= 1'b0;
      end else begin
         inv_temp_ff  <= inv_temp_in;
         field_str_ff <= field_str_in;
         field_dir_ff <= field_dir_in;
         diag_ff      <= diag_in;
      end
   end

   // Register reads
   always_comb begin
      case (paddr[3:2])
         CSR_INV_TEMP:  prdata = CSR_DATA_W'(inv_temp_ff);
         CSR_FIELD_STR: prdata = CSR_DATA_W'(field_str_ff);
         CSR_FIELD_DIR: prdata = CSR_DATA_W'(field_dir_ff);
         CSR_DIAGONAL:  prdata = CSR_DATA_W'(diag_ff);
         default:       prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   pmsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pmsu_dpath u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_mode                (req_mode),
      .req_site_x              (req_site_x),
      .req_site_y              (req_site_y),
      .req_proposed_spin       (req_proposed_spin),
      .req_random_value        (req_random_value),
      .inv_temperature         (inv_temp_ff),
      .field_weight            (field_str_ff),
      .field_direction         (field_dir_ff),
      .include_diagonal        (diag_ff),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_energy_change       (rsp_energy_change),
      .rsp_accepted            (rsp_accepted),
      .rsp_old_spin            (rsp_old_spin),
      .rsp_energy_total        (rsp_energy_total),
      .rsp_magnetization_total (rsp_magnetization_total)
   );

endmodule

>>> tb/potts_site_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// potts_site_update_checker
// Watches the request, result and register channels of the Potts site update
// core. Keeps its own copy of the lattice, the totals and the registers,
// predicts the result of each accepted request and compares every accepted
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module potts_site_update_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [pmsu_pkg::SITE_W-1:0]          req_site_x,
   input  logic [pmsu_pkg::SITE_W-1:0]          req_site_y,
   input  logic [pmsu_pkg::SPIN_W-1:0]          req_proposed_spin,
   input  logic [pmsu_pkg::RND_W-1:0]           req_random_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [pmsu_pkg::DE_W-1:0]     rsp_energy_change,
   input  logic                                 rsp_accepted,
   input  logic [pmsu_pkg::SPIN_W-1:0]          rsp_old_spin,
   input  logic signed [pmsu_pkg::ETOT_W-1:0]   rsp_energy_total,
   input  logic [pmsu_pkg::MAG_W-1:0]           rsp_magnetization_total,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pmsu_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [pmsu_pkg::CSR_DATA_W-1:0]      pwdata,
   input  logic                                 pready,
   output int                                   outstanding,
   output int                                   mismatch_count
);
   import pmsu_pkg::*;

   localparam int unsigned THRESHOLD_CUTOFF = 355;
   localparam int          DECAY_POWERS     = 9;
   localparam int          PRINT_LIMIT      = 200;

   typedef struct packed {
      logic signed [DE_W-1:0]   energy_change;
      logic                     accepted;
      logic [SPIN_W-1:0]        old_spin;
      logic signed [ETOT_W-1:0] energy_total;
      logic [MAG_W-1:0]         magnetization_total;
   } site_result_type;

   // Mirror of the block state and registers
   logic [SPIN_W-1:0] spin_mirror [0:LAT_W*LAT_H-1];
   logic [ETOT_W-1:0] energy_sum;
   logic [MAG_W-1:0]  magnetization_sum;
   logic [TEMP_W-1:0] inv_temperature;
   logic [FSTR_W-1:0] field_weight;
   logic [SPIN_W-1:0] field_direction;
   logic              include_diagonal;

   // exp(-2^k/32) in Q0.64, formed by repeated squaring
   logic [63:0] decay_pow [DECAY_POWERS];

   site_result_type pending_site_results [$];

   function automatic logic [63:0] q64_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return full[127:64];
   endfunction

   // Build the decay step from the alternating series, then its powers
   initial begin : build_decay_table
      logic [63:0] term;
      logic [63:0] step;
      term = 64'd1 << 59;
      step = 64'd0;
      for (int k = 1; k <= 12; k++) begin
         if (k % 2 == 1) step = step - term;
         else step = step + term;
         term = term / (64'd32 * (k + 1));
      end
      decay_pow[0] = step;
      for (int k = 1; k < DECAY_POWERS; k++)
         decay_pow[k] = q64_mul(decay_pow[k-1], decay_pow[k-1]);
   end

   // Work out one request against the mirror and advance the mirror
   function automatic site_result_type predict_site_update(
      input logic              is_trial,
      input logic [SITE_W-1:0] x,
      input logic [SITE_W-1:0] y,
      input logic [SPIN_W-1:0] new_spin,
      input logic [RND_W-1:0]  rnd
   );
      site_result_type r;
      int unsigned  idx;
      logic [SPIN_W-1:0] cur_spin;
      logic [SPIN_W-1:0] nb;
      int           de;
      int           nx;
      int           ny;
      int           bonus_cur;
      int           bonus_new;
      int unsigned  prod;
      int unsigned  thr;
      logic [63:0]  res;
      bit           have;
      logic         acc;
      idx = 32'({y, x});
      cur_spin = spin_mirror[idx];
      de = 0;
      acc = 1'b0;
      if (!is_trial) begin
         acc = 1'b1;
      end else begin
         bonus_cur = (cur_spin == field_direction) ? int'(field_weight) : 0;
         bonus_new = (new_spin == field_direction) ? int'(field_weight) : 0;
         // Sum over in-lattice neighbors, diagonals only when enabled
         for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
               nx = int'(x) + dx;
               ny = int'(y) + dy;
               if (dx == 0 && dy == 0) continue;
               if (dx != 0 && dy != 0 && !include_diagonal) continue;
               if (nx < 0 || ny < 0 || nx >= LAT_W || ny >= LAT_H) continue;
               nb = spin_mirror[ny*LAT_W + nx];
               de += ((nb == cur_spin) ? 1 : -1) + bonus_cur;
               de -= ((nb == new_spin) ? 1 : -1) + bonus_new;
            end
         end
         if (de <= 0) begin
            acc = 1'b1;
         end else begin
            // Threshold: top 16 bits of exp(-p/32), saturated and cut off
            prod = de * int'(inv_temperature);
            if (prod == 0) begin
               thr = 65535;
            end else if (prod >= THRESHOLD_CUTOFF) begin
               thr = 0;
            end else begin
               res = 64'd0;
               have = 1'b0;
               for (int k = 0; k < DECAY_POWERS; k++) begin
                  if (prod[k]) begin
                     res = have ? q64_mul(res, decay_pow[k]) : decay_pow[k];
                     have = 1'b1;
                  end
               end
               thr = 32'(res[63:48]);
            end
            acc = (int'(rnd) < thr);
         end
         if (acc) energy_sum = energy_sum + ETOT_W'(de);
      end
      if (acc) begin
         spin_mirror[idx] = new_spin;
         magnetization_sum = magnetization_sum - cur_spin + new_spin;
      end
      r.energy_change       = DE_W'(de);
      r.accepted            = acc;
      r.old_spin            = cur_spin;
      r.energy_total        = energy_sum;
      r.magnetization_total = magnetization_sum;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch_channels
      site_result_type want;
      if (reset) begin
         // Return the mirror to its reset state
         for (int i = 0; i < LAT_W*LAT_H; i++) spin_mirror[i] = '0;
         energy_sum        = '0;
         magnetization_sum = '0;
         inv_temperature   = INV_TEMP_RESET;
         field_weight      = '0;
         field_direction   = '0;
         include_diagonal  = 1'b0;
         pending_site_results.delete();
      end else begin
         // Track register writes
         if (psel && penable && pwrite && pready) begin
            case (csr_idx_type'(paddr[3:2]))
               CSR_INV_TEMP:  inv_temperature  = pwdata[TEMP_W-1:0];
               CSR_FIELD_STR: field_weight     = pwdata[FSTR_W-1:0];
               CSR_FIELD_DIR: field_direction  = pwdata[SPIN_W-1:0];
               CSR_DIAGONAL:  include_diagonal = pwdata[0];
               default: ;
            endcase
         end
         // Predict each accepted request
         if (req_valid && req_ready)
            pending_site_results.insert(pending_site_results.size(),
               predict_site_update(req_mode, req_site_x, req_site_y,
                  req_proposed_spin, req_random_value));
         // Compare each accepted result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pending_site_results.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = pending_site_results.pop_front();
               if (rsp_energy_change !== want.energy_change)
                  report_mismatch($sformatf("energy_change got %0d expected %0d",
                     rsp_energy_change, want.energy_change));
               if (rsp_accepted !== want.accepted)
                  report_mismatch($sformatf("accepted got %0d expected %0d",
                     rsp_accepted, want.accepted));
               if (rsp_old_spin !== want.old_spin)
                  report_mismatch($sformatf("old_spin got %0d expected %0d",
                     rsp_old_spin, want.old_spin));
               if (rsp_energy_total !== want.energy_total)
                  report_mismatch($sformatf("energy_total got %0d expected %0d",
                     rsp_energy_total, want.energy_total));
               if (rsp_magnetization_total !== want.magnetization_total)
                  report_mismatch($sformatf("magnetization_total got %0d expected %0d",
                     rsp_magnetization_total, want.magnetization_total));
            end
         end
      end
      outstanding = pending_site_results.size();
   end

endmodule

>>> tb/potts_metropolis_site_update_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// potts_metropolis_site_update_core_tb
// Drives load and trial requests into the Potts site update core under a
// series of register settings, with random gaps on the request side and
// random stalls on the result side. The checker beside the core predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module potts_metropolis_site_update_core_tb;
   import pmsu_pkg::*;

   localparam logic MODE_LOAD      = 1'b0;
   localparam logic MODE_TRIAL     = 1'b1;
   localparam int   IDLE_PERCENT   = 33;
   localparam int   PHASE_ITEMS    = 200;
   // Covers the lattice clearing pass after reset several times over
   localparam int   WATCHDOG_LIMIT = 200000;
   localparam int   DRAIN_CYCLES   = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_mode = MODE_LOAD;
   logic [SITE_W-1:0]          req_site_x = '0;
   logic [SITE_W-1:0]          req_site_y = '0;
   logic [SPIN_W-1:0]          req_proposed_spin = '0;
   logic [RND_W-1:0]           req_random_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [DE_W-1:0]     rsp_energy_change;
   logic                       rsp_accepted;
   logic [SPIN_W-1:0]          rsp_old_spin;
   logic signed [ETOT_W-1:0]   rsp_energy_total;
   logic [MAG_W-1:0]           rsp_magnetization_total;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr = '0;
   logic [CSR_DATA_W-1:0]      pwdata = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   int outstanding;
   int mismatch_count;
   bit idle_on = 1'b1;

   potts_metropolis_site_update_core u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_mode                (req_mode),
      .req_site_x              (req_site_x),
      .req_site_y              (req_site_y),
      .req_proposed_spin       (req_proposed_spin),
      .req_random_value        (req_random_value),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_energy_change       (rsp_energy_change),
      .rsp_accepted            (rsp_accepted),
      .rsp_old_spin            (rsp_old_spin),
      .rsp_energy_total        (rsp_energy_total),
      .rsp_magnetization_total (rsp_magnetization_total),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready)
   );

   potts_site_update_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_mode                (req_mode),
      .req_site_x              (req_site_x),
      .req_site_y              (req_site_y),
      .req_proposed_spin       (req_proposed_spin),
      .req_random_value        (req_random_value),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_energy_change       (rsp_energy_change),
      .rsp_accepted            (rsp_accepted),
      .rsp_old_spin            (rsp_old_spin),
      .rsp_energy_total        (rsp_energy_total),
      .rsp_magnetization_total (rsp_magnetization_total),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .pready                  (pready),
      .outstanding             (outstanding),
      .mismatch_count          (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random while idling is on
   always @(negedge clock) begin
      rsp_ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Send one request; entered and left at a falling edge
   task automatic send_request(
      input logic              mode,
      input logic [SITE_W-1:0] x,
      input logic [SITE_W-1:0] y,
      input logic [SPIN_W-1:0] spin,
      input logic [RND_W-1:0]  rnd
   );
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_site_x        <= x;
      req_site_y        <= y;
      req_proposed_spin <= spin;
      req_random_value  <= rnd;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Random request, mostly packed into small windows at edges and center
   task automatic send_random_request();
      logic              mode;
      logic [SITE_W-1:0] x;
      logic [SITE_W-1:0] y;
      logic [SPIN_W-1:0] spin;
      logic [RND_W-1:0]  rnd;
      int                wsel;
      mode = ($urandom_range(99) < 70) ? MODE_TRIAL : MODE_LOAD;
      if ($urandom_range(99) < 10) begin
         x = SITE_W'($urandom_range(255));
         y = SITE_W'($urandom_range(255));
      end else begin
         wsel = $urandom_range(2);
         x = (wsel == 0) ? SITE_W'(0) : ((wsel == 1) ? SITE_W'(124) : SITE_W'(248));
         x = x + SITE_W'($urandom_range(7));
         wsel = $urandom_range(2);
         y = (wsel == 0) ? SITE_W'(0) : ((wsel == 1) ? SITE_W'(124) : SITE_W'(248));
         y = y + SITE_W'($urandom_range(7));
      end
      spin = ($urandom_range(99) < 85) ? SPIN_W'($urandom_range(8))
                                       : SPIN_W'($urandom_range(15));
      case ($urandom_range(19))
         0:       rnd = '0;
         1:       rnd = '1;
         default: rnd = RND_W'($urandom_range(65535));
      endcase
      send_request(mode, x, y, spin, rnd);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Drain the core, then write every register
   task automatic configure(
      input logic [TEMP_W-1:0] inv_temp,
      input logic [FSTR_W-1:0] fstr,
      input logic [SPIN_W-1:0] fdir,
      input logic              diag
   );
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      csr_write(CSR_INV_TEMP, CSR_DATA_W'(inv_temp));
      csr_write(CSR_FIELD_STR, CSR_DATA_W'(fstr));
      csr_write(CSR_FIELD_DIR, CSR_DATA_W'(fdir));
      csr_write(CSR_DIAGONAL, CSR_DATA_W'(diag));
   endtask

   task automatic send_random_requests(input int count);
      repeat (count) send_random_request();
   endtask

   // Stop the run when the channels go quiet for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: corners, high spins, edges, diagonal field bonus
      configure(8'd32, 2'd1, 4'd3, 1'b1);
      send_request(MODE_LOAD, 8'd0, 8'd0, 4'd15, 16'd0);
      send_request(MODE_LOAD, 8'd255, 8'd255, 4'd8, 16'hFFFF);
      send_request(MODE_LOAD, 8'd255, 8'd0, 4'd3, 16'd0);
      send_request(MODE_LOAD, 8'd0, 8'd255, 4'd9, 16'hFFFF);
      send_request(MODE_LOAD, 8'd1, 8'd0, 4'd3, 16'd0);
      send_request(MODE_LOAD, 8'd0, 8'd1, 4'd3, 16'd0);
      send_request(MODE_LOAD, 8'd1, 8'd1, 4'd5, 16'd0);
      send_request(MODE_TRIAL, 8'd0, 8'd0, 4'd3, 16'd0);
      send_request(MODE_TRIAL, 8'd255, 8'd255, 4'd8, 16'hFFFF);
      send_request(MODE_TRIAL, 8'd255, 8'd0, 4'd15, 16'hFFFF);
      send_request(MODE_TRIAL, 8'd255, 8'd0, 4'd15, 16'd0);
      send_request(MODE_TRIAL, 8'd128, 8'd128, 4'd1, 16'hAAAA);
      send_request(MODE_TRIAL, 8'd128, 8'd128, 4'd0, 16'h5555);
      send_request(MODE_TRIAL, 8'd254, 8'd254, 4'd12, 16'hFFFF);
      send_request(MODE_LOAD, 8'd127, 8'd127, 4'd15, 16'd0);
      send_request(MODE_TRIAL, 8'd127, 8'd128, 4'd15, 16'd1);
      send_request(MODE_TRIAL, 8'd0, 8'd1, 4'd3, 16'd0);
      send_random_requests(PHASE_ITEMS);

      // Zero inverse temperature: saturated threshold, only the top value rejects
      configure(8'd0, 2'd0, 4'd0, 1'b0);
      send_request(MODE_TRIAL, 8'd200, 8'd200, 4'd2, 16'hFFFF);
      send_request(MODE_TRIAL, 8'd200, 8'd200, 4'd2, 16'hFFFE);
      send_request(MODE_TRIAL, 8'd200, 8'd200, 4'd2, 16'hFFFF);
      send_random_requests(PHASE_ITEMS);

      // Coldest setting, strongest field on the top spin value
      configure(8'd255, 2'd3, 4'd15, 1'b1);
      send_random_requests(PHASE_ITEMS);

      // Hold both sides busy through a whole phase
      configure(8'd5, 2'd2, 4'd8, 1'b0);
      idle_on = 1'b0;
      send_random_requests(PHASE_ITEMS);
      idle_on = 1'b1;

      configure(8'd1, 2'd1, 4'd0, 1'b1);
      send_random_requests(PHASE_ITEMS);

      repeat (3) begin
         configure(TEMP_W'($urandom_range(255)), FSTR_W'($urandom_range(3)),
                   SPIN_W'($urandom_range(15)), 1'($urandom_range(1)));
         send_random_requests(PHASE_ITEMS);
      end

      // Drain and give the verdict
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
